@@ sv/mtfq_pkg.sv @@
// Shared types and constants for the move-to-front service queue.
package mtfq_pkg;

    // Widths fixed by the transaction fields
    localparam int ID_W     = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 2;

    // Cells per group in the match scan
    localparam int GRP_SIZE = 32;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_SERVE    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_EXPEDITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESTART  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_SERVED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;

    // Register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_POPULATION = 2'd0;

    // Broadcast controls for every cell of the chain
    typedef struct packed {
        logic serve;     // rotate front to the back of the list
        logic expedite;  // apply the move-to-front shift
        logic restart;   // reload ids 1..n
        logic found;     // expedited id is present in the list
    } cell_ctl_t;

endpackage

@@ sv/mtfq_cell.sv @@
// One list position: holds an id, compares it and takes data from its neighbors.
module mtfq_cell #(
    parameter int CELL_IDX = 0,
    parameter int LEN_W    = 11
) (
    input  logic                      clk,
    input  mtfq_pkg::cell_ctl_t       ctl,
    input  logic [LEN_W-1:0]          len,
    input  logic [LEN_W-1:0]          fill_count,
    input  logic [mtfq_pkg::ID_W-1:0] pid,
    input  logic [mtfq_pkg::ID_W-1:0] prev_id,
    input  logic [mtfq_pkg::ID_W-1:0] next_id,
    input  logic [mtfq_pkg::ID_W-1:0] front_id,
    input  logic                      earlier,
    output logic [mtfq_pkg::ID_W-1:0] id,
    output logic                      match
);

    localparam logic [LEN_W-1:0]          POS      = LEN_W'(CELL_IDX);
    localparam logic [LEN_W-1:0]          POS1     = LEN_W'(CELL_IDX + 1);
    localparam logic [mtfq_pkg::ID_W-1:0] LOAD_VAL = mtfq_pkg::ID_W'(CELL_IDX + 1);

    logic [mtfq_pkg::ID_W-1:0] id_reg;
    logic [mtfq_pkg::ID_W-1:0] id_next;
    logic                      match_reg;
    logic                      match_next;

    // Select the next id from the neighbors, the front entry, the search id or the reload value
    always_comb
    begin
        id_next = id_reg;
        priority if (ctl.serve)
        begin
            if (POS1 < len)
            begin
                id_next = next_id;
            end
            else if (POS1 == len)
            begin
                id_next = front_id;
            end
        end
        else if (ctl.expedite)
        begin
            if (CELL_IDX == 0)
            begin
                id_next = pid;
            end
            else if (!earlier && (ctl.found || POS <= len))
            begin
                id_next = prev_id;
            end
        end
        else if (ctl.restart)
        begin
            if (POS < fill_count)
            begin
                id_next = LOAD_VAL;
            end
        end
        else
        begin
            id_next = id_reg;
        end
    end

    // Compare against the id under search, valid entries only
    assign match_next = (id_reg == pid) && (POS < len);

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        match_reg <= match_next;
    end

    assign id    = id_reg;
    assign match = match_reg;

endmodule

@@ sv/mtfq_scan.sv @@
// Two-level registered scan: flags cells that lie behind a matching cell.
module mtfq_scan #(
    parameter int CAPACITY = 1024
) (
    input  logic                clk,
    input  logic [CAPACITY-1:0] match,
    output logic [CAPACITY-1:0] earlier,
    output logic                found
);

    localparam int NGRP = (CAPACITY + mtfq_pkg::GRP_SIZE - 1) / mtfq_pkg::GRP_SIZE;

    logic [CAPACITY-1:0] in_grp_next;
    logic [CAPACITY-1:0] in_grp_reg;
    logic [NGRP-1:0]     grp_any_next;
    logic [NGRP-1:0]     grp_any_reg;
    logic [NGRP-1:0]     grp_before;

    // Prefix OR of matches inside each cell's own group
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        localparam int BASE = (k / mtfq_pkg::GRP_SIZE) * mtfq_pkg::GRP_SIZE;
        logic acc;
        always_comb
        begin
            acc = 1'b0;
            for (int j = BASE; j < k; j++)
            begin
                acc = acc | match[j];
            end
        end
        assign in_grp_next[k] = acc;
        assign earlier[k]     = in_grp_reg[k] | grp_before[k / mtfq_pkg::GRP_SIZE];
    end

    // Any match per group, then prefix over the groups below
    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        localparam int LO = g * mtfq_pkg::GRP_SIZE;
        localparam int HI = (LO + mtfq_pkg::GRP_SIZE < CAPACITY) ?
                            (LO + mtfq_pkg::GRP_SIZE) : CAPACITY;
        logic any;
        logic below;
        always_comb
        begin
            any = 1'b0;
            for (int j = LO; j < HI; j++)
            begin
                any = any | match[j];
            end
        end
        always_comb
        begin
            below = 1'b0;
            for (int j = 0; j < g; j++)
            begin
                below = below | grp_any_reg[j];
            end
        end
        assign grp_any_next[g] = any;
        assign grp_before[g]   = below;
    end

    always_ff @(posedge clk)
    begin
        in_grp_reg  <= in_grp_next;
        grp_any_reg <= grp_any_next;
    end

    assign found = |grp_any_reg;

endmodule

@@ sv/move_to_front_service_queue.sv @@
// Top level of the move-to-front service queue: control, cell chain and config port.
//
// Usage:
//   Commands enter on start/action/person_id and are taken at a rising edge with
//   start high and busy low. Every command yields one result: served_id and
//   status are valid for exactly one cycle while done is high.
//   Serve, restart and an unknown action finish in one cycle: done rises in the
//   cycle after the transaction is taken, and a new command may be taken then.
//   Expedite: cells compare the id in the accept cycle, a group scan is registered
//   in the next, and the shift is applied in the state after that; done follows
//   in the cycle after. busy is high while the scan is registered and the shift
//   is applied. The two registered levels of the match scan set this sequence.
//   The population register sits at byte address 0 of the APB port; write it
//   only while no command is in flight.
//   Reset empties the list and clears population; list contents are not
//   cleared, only the length. done is never held off: the receiver takes each
//   result in its cycle.
module move_to_front_service_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mtfq_pkg::ACTION_W-1:0] action,
    input  logic [mtfq_pkg::ID_W-1:0]     person_id,
    output logic                          done,
    output logic [mtfq_pkg::ID_W-1:0]     served_id,
    output logic [mtfq_pkg::STATUS_W-1:0] status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mtfq_pkg::ADDR_W-1:0]   paddr,
    input  logic [mtfq_pkg::DATA_W-1:0]   pwdata,
    output logic [mtfq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_GROUP = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [LEN_W-1:0]                len_reg;
    logic [LEN_W-1:0]                len_next;
    logic [mtfq_pkg::DATA_W-1:0]     population_reg;
    logic [mtfq_pkg::ID_W-1:0]       pid_reg;
    logic [mtfq_pkg::ID_W-1:0]       pid_next;
    logic                            done_reg;
    logic                            done_next;
    logic [mtfq_pkg::ID_W-1:0]       served_reg;
    logic [mtfq_pkg::ID_W-1:0]       served_next;
    logic [mtfq_pkg::STATUS_W-1:0]   status_reg;
    logic [mtfq_pkg::STATUS_W-1:0]   status_next;

    logic                            accept;
    logic                            cfg_write;
    logic [LEN_W-1:0]                fill_count;
    logic [mtfq_pkg::ID_W-1:0]       cmp_pid;
    logic                            found;
    logic [CAPACITY-1:0]             match;
    logic [CAPACITY-1:0]             earlier;
    logic [mtfq_pkg::ID_W-1:0]       ids [CAPACITY];
    mtfq_pkg::cell_ctl_t             ctl;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;

    // Restart length saturates at the capacity
    assign fill_count = (population_reg > mtfq_pkg::DATA_W'(CAPACITY)) ?
                        CAP_LEN : population_reg[LEN_W-1:0];

    // Search id comes from the port while idle, from the holding register later
    assign cmp_pid = busy ? pid_reg : person_id;

    // Broadcast controls
    always_comb
    begin
        ctl.serve    = accept && (action == mtfq_pkg::ACT_SERVE) && (len_reg != '0);
        ctl.restart  = accept && (action == mtfq_pkg::ACT_RESTART);
        ctl.expedite = (state_reg == ST_APPLY);
        ctl.found    = found;
    end

    // Cell chain
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_chain
        logic [mtfq_pkg::ID_W-1:0] prev_id;
        logic [mtfq_pkg::ID_W-1:0] next_id;
        if (k == 0)
        begin : g_first
            assign prev_id = '0;
        end
        else
        begin : g_mid
            assign prev_id = ids[k-1];
        end
        if (k == CAPACITY - 1)
        begin : g_last
            assign next_id = '0;
        end
        else
        begin : g_inner
            assign next_id = ids[k+1];
        end
        mtfq_cell #(
            .CELL_IDX (k),
            .LEN_W    (LEN_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .len        (len_reg),
            .fill_count (fill_count),
            .pid        (cmp_pid),
            .prev_id    (prev_id),
            .next_id    (next_id),
            .front_id   (ids[0]),
            .earlier    (earlier[k]),
            .id         (ids[k]),
            .match      (match[k])
        );
    end

    mtfq_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .clk     (clk),
        .match   (match),
        .earlier (earlier),
        .found   (found)
    );

    // Sequence commands and build results
    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        pid_next    = pid_reg;
        done_next   = 1'b0;
        served_next = '0;
        status_next = mtfq_pkg::STAT_DONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        mtfq_pkg::ACT_SERVE:
                        begin
                            done_next = 1'b1;
                            if (len_reg == '0)
                            begin
                                status_next = mtfq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                served_next = ids[0];
                                status_next = mtfq_pkg::STAT_SERVED;
                            end
                        end
                        mtfq_pkg::ACT_EXPEDITE:
                        begin
                            pid_next   = person_id;
                            state_next = ST_GROUP;
                        end
                        mtfq_pkg::ACT_RESTART:
                        begin
                            done_next = 1'b1;
                            len_next  = fill_count;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_GROUP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (!found && (len_reg != CAP_LEN))
                begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            done_reg       <= 1'b0;
            population_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            done_reg  <= done_next;
            if (cfg_write && (paddr == mtfq_pkg::ADDR_POPULATION))
            begin
                population_reg <= pwdata;
            end
        end
    end

    // Payload holding registers
    always_ff @(posedge clk)
    begin
        pid_reg    <= pid_next;
        served_reg <= served_next;
        status_reg <= status_next;
    end

    assign done      = done_reg;
    assign served_id = served_reg;
    assign status    = status_reg;

    // Register readback
    assign pready = 1'b1;
    assign prdata = (paddr == mtfq_pkg::ADDR_POPULATION) ? population_reg : '0;

endmodule

@@ sv/mtfq_checker.sv @@
// Port-level checks on command and result timing of the service queue.
module mtfq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [mtfq_pkg::ACTION_W-1:0] action,
    input logic                          done,
    input logic [mtfq_pkg::ID_W-1:0]     served_id,
    input logic [mtfq_pkg::STATUS_W-1:0] status
);

    // Non-expedite commands report in the next cycle
    a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action != mtfq_pkg::ACT_EXPEDITE)) |=> (done && !busy))
        else $error("single-cycle command did not report next cycle");

    // Expedite holds busy through ST_GROUP and ST_APPLY, then reports with busy low
    a_expedite_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == mtfq_pkg::ACT_EXPEDITE)) |=>
        busy ##1 busy ##1 (done && !busy))
        else $error("expedite timing wrong");

    // A result never appears while a command is still in flight
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // Only a serve result carries an id
    a_served_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != mtfq_pkg::STAT_SERVED)) |-> (served_id == '0))
        else $error("nonzero id on a non-serve result");

endmodule

bind move_to_front_service_queue mtfq_checker u_mtfq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .done      (done),
    .served_id (served_id),
    .status    (status)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the move-to-front service queue.
`timescale 1ns / 100ps

module testbench;

    localparam int CAPACITY = 1024;

    // Action code with no meaning to the block: it must answer done and change nothing
    localparam logic [mtfq_pkg::ACTION_W-1:0] ACT_IGNORED = 2'd3;

    typedef struct packed {
        logic [mtfq_pkg::ACTION_W-1:0] action;
        logic [mtfq_pkg::ID_W-1:0]     person_id;
    } command_t;

    typedef struct packed {
        logic [mtfq_pkg::ID_W-1:0]     served_id;
        logic [mtfq_pkg::STATUS_W-1:0] status;
    } outcome_t;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          start     = 1'b0;
    logic                          busy;
    logic [mtfq_pkg::ACTION_W-1:0] action    = '0;
    logic [mtfq_pkg::ID_W-1:0]     person_id = '0;
    logic                          done;
    logic [mtfq_pkg::ID_W-1:0]     served_id;
    logic [mtfq_pkg::STATUS_W-1:0] status;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [mtfq_pkg::ADDR_W-1:0]   paddr     = '0;
    logic [mtfq_pkg::DATA_W-1:0]   pwdata    = '0;
    logic [mtfq_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // Commands waiting to be sent and outcomes waiting to come back
    command_t pending_cmds[$];
    outcome_t expected_outcomes[$];
    logic [mtfq_pkg::ID_W-1:0] outsider_ids[$];

    // Mirror of the service line and its population register
    logic [mtfq_pkg::ID_W-1:0]   line_ids [CAPACITY];
    int                          line_len       = 0;
    logic [mtfq_pkg::DATA_W-1:0] population_cfg = '0;

    int       mismatches = 0;
    logic     taken      = 1'b0;
    int       burst_left = 0;
    int       gap_left   = 0;
    command_t next_cmd;
    outcome_t got_outcome;
    outcome_t want_outcome;

    move_to_front_service_queue #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .person_id (person_id),
        .done      (done),
        .served_id (served_id),
        .status    (status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Apply one command to the mirrored line and return the outcome it must produce
    function automatic outcome_t apply_to_line(input command_t cmd);
        outcome_t                  res;
        logic [mtfq_pkg::ID_W-1:0] front;
        int                        k;
        int                        pos;
        int                        upto;
        int                        fill;
        res.served_id = '0;
        res.status    = mtfq_pkg::STAT_DONE;
        case (cmd.action)
            mtfq_pkg::ACT_SERVE:
            begin
                if (line_len == 0)
                begin
                    res.status = mtfq_pkg::STAT_EMPTY;
                end
                else
                begin
                    // rotate the front entry to the back
                    front = line_ids[0];
                    for (k = 0; k + 1 < line_len; k++)
                        line_ids[k] = line_ids[k + 1];
                    line_ids[line_len - 1] = front;
                    res.served_id = front;
                    res.status    = mtfq_pkg::STAT_SERVED;
                end
            end
            mtfq_pkg::ACT_EXPEDITE:
            begin
                // find the first match; absent leaves pos at the length
                pos = line_len;
                for (k = line_len - 1; k >= 0; k--)
                    if (line_ids[k] == cmd.person_id)
                        pos = k;
                if (pos < line_len)
                    upto = pos;
                else if (line_len < CAPACITY)
                begin
                    upto     = line_len;
                    line_len = line_len + 1;
                end
                else
                    upto = CAPACITY - 1;
                for (k = upto; k > 0; k--)
                    line_ids[k] = line_ids[k - 1];
                line_ids[0] = cmd.person_id;
            end
            mtfq_pkg::ACT_RESTART:
            begin
                // reload 1..n, saturating at the capacity
                fill = (population_cfg > 32'(CAPACITY)) ? CAPACITY : int'(population_cfg);
                for (k = 0; k < fill; k++)
                    line_ids[k] = mtfq_pkg::ID_W'(k + 1);
                line_len = fill;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic void queue_cmd(input logic [mtfq_pkg::ACTION_W-1:0] act,
                                      input logic [mtfq_pkg::ID_W-1:0] id);
        command_t c;
        c.action    = act;
        c.person_id = id;
        pending_cmds = {pending_cmds, c};
    endfunction

    // Random command, biased so that most expedites hit ids already in the line
    function automatic command_t random_command(input logic [mtfq_pkg::DATA_W-1:0] pop);
        command_t c;
        int       roll;
        int       id_hi;
        roll        = $urandom_range(0, 99);
        c.person_id = $urandom;
        if (roll < 35)
            c.action = mtfq_pkg::ACT_SERVE;
        else if (roll < 83)
            c.action = mtfq_pkg::ACT_EXPEDITE;
        else if (roll < 93)
            c.action = mtfq_pkg::ACT_RESTART;
        else
            c.action = ACT_IGNORED;
        if (c.action == mtfq_pkg::ACT_EXPEDITE)
        begin
            id_hi = (pop > 32'(CAPACITY)) ? CAPACITY + 3 : int'(pop) + 3;
            roll  = $urandom_range(0, 99);
            if (roll < 60)
                c.person_id = $urandom_range(1, id_hi);
            else if (roll < 75 && outsider_ids.size() > 0)
                c.person_id = outsider_ids[$urandom_range(0, outsider_ids.size() - 1)];
            else if (roll < 90)
            begin
                // remember a fresh outsider so later expedites find it again
                if (outsider_ids.size() >= 16)
                    void'(outsider_ids.pop_front());
                outsider_ids = {outsider_ids, c.person_id};
            end
            else
                c.person_id = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        return c;
    endfunction

    // Hold until nothing is queued, nothing is on the port and every outcome has come
    task automatic wait_until_drained();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending_cmds.size() != 0 || expected_outcomes.size() != 0 || start);
    endtask

    // Write the population register, then read it back
    task automatic write_population(input logic [mtfq_pkg::DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mtfq_pkg::ADDR_POPULATION;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        population_cfg = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== value)
        begin
            $display("%0t: population readback expected %h got %h", $realtime, value, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Driver: send commands in bursts separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!start || taken))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                next_cmd = pending_cmds.pop_front();
                start     <= 1'b1;
                action    <= next_cmd.action;
                person_id <= next_cmd.person_id;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left = burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check each result against the oldest outcome, then log new transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                got_outcome.served_id = served_id;
                got_outcome.status    = status;
                if (expected_outcomes.size() == 0)
                begin
                    $display("%0t: result with none outstanding, expected none got %h/%h",
                             $realtime, served_id, status);
                    mismatches++;
                end
                else
                begin
                    want_outcome = expected_outcomes.pop_front();
                    if (got_outcome.served_id !== want_outcome.served_id)
                    begin
                        $display("%0t: served_id expected %h got %h", $realtime,
                                 want_outcome.served_id, got_outcome.served_id);
                        mismatches++;
                    end
                    if (got_outcome.status !== want_outcome.status)
                    begin
                        $display("%0t: status expected %0d got %0d", $realtime,
                                 want_outcome.status, got_outcome.status);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                next_cmd.action    = action;
                next_cmd.person_id = person_id;
                expected_outcomes = {expected_outcomes, apply_to_line(next_cmd)};
                taken <= 1'b1;
            end
            else
                taken <= 1'b0;
        end
    end

    // Sequence: reset, directed phases, then random phases at several populations
    initial
    begin
        logic [mtfq_pkg::DATA_W-1:0] phase_pops [8];
        int                          p;
        int                          n;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list: serve on empty, unknown action, insert into empty, expedite of the front
        write_population('0);
        queue_cmd(mtfq_pkg::ACT_SERVE, 32'h0000_0000);
        queue_cmd(ACT_IGNORED, 32'hFFFF_FFFF);
        queue_cmd(mtfq_pkg::ACT_RESTART, 32'h1234_5678);
        queue_cmd(mtfq_pkg::ACT_SERVE, 32'hFFFF_FFFF);
        queue_cmd(mtfq_pkg::ACT_EXPEDITE, 32'd5);
        queue_cmd(mtfq_pkg::ACT_EXPEDITE, 32'd5);
        queue_cmd(mtfq_pkg::ACT_SERVE, 32'd0);
        wait_until_drained();

        // short list: move from middle and tail, insert absent ids at both id extremes
        write_population(32'd4);
        queue_cmd(mtfq_pkg::ACT_RESTART, 32'd0);
        queue_cmd(mtfq_pkg::ACT_EXPEDITE, 32'd3);
        queue_cmd(mtfq_pkg::ACT_EXPEDITE, 32'd4);
        queue_cmd(mtfq_pkg::ACT_EXPEDITE, 32'hFFFF_FFFF);
        queue_cmd(mtfq_pkg::ACT_EXPEDITE, 32'h0000_0000);
        queue_cmd(mtfq_pkg::ACT_SERVE, 32'd0);
        queue_cmd(mtfq_pkg::ACT_SERVE, 32'd0);
        queue_cmd(ACT_IGNORED, 32'd0);
        wait_until_drained();

        // full list: insert an outsider and drop the tail, then bring the dropped id back
        write_population(32'(CAPACITY));
        queue_cmd(mtfq_pkg::ACT_RESTART, 32'd0);
        queue_cmd(mtfq_pkg::ACT_EXPEDITE, 32'hA5A5_5A5A);
        queue_cmd(mtfq_pkg::ACT_EXPEDITE, 32'(CAPACITY));
        queue_cmd(mtfq_pkg::ACT_EXPEDITE, 32'd1);
        queue_cmd(mtfq_pkg::ACT_SERVE, 32'd0);
        wait_until_drained();

        // population far above capacity saturates; expedite the tail entry
        write_population(32'hFFFF_FFFF);
        queue_cmd(mtfq_pkg::ACT_RESTART, 32'd0);
        queue_cmd(mtfq_pkg::ACT_EXPEDITE, 32'(CAPACITY));
        queue_cmd(mtfq_pkg::ACT_SERVE, 32'd0);
        wait_until_drained();

        phase_pops[0] = 32'd2;
        phase_pops[1] = $urandom_range(3, 40);
        phase_pops[2] = 32'(CAPACITY - 1);
        phase_pops[3] = 32'(CAPACITY);
        phase_pops[4] = 32'd0;
        phase_pops[5] = 32'hFFFF_FFFF;
        phase_pops[6] = $urandom;
        phase_pops[7] = $urandom_range(1, 12);

        // each random phase opens with a restart so the line starts well formed
        for (p = 0; p < 8; p++)
        begin
            write_population(phase_pops[p]);
            queue_cmd(mtfq_pkg::ACT_RESTART, $urandom);
            for (n = 0; n < 199; n++)
                pending_cmds = {pending_cmds, random_command(phase_pops[p])};
            wait_until_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
